// ===== rtl/core/day_number_to_date_defines.svh =====
// Assertion helpers shared by the day-number-to-date modules.
// Each helper expects clk_i and rst_ni in the scope where it is used.
`ifndef DAY_NUMBER_TO_DATE_DEFINES_SVH
`define DAY_NUMBER_TO_DATE_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define DND_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition in one cycle implies a consequence in the next.
`define DND_ASSERT_NEXT(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond) |=> (conseq)) else $error(msg);

`endif

// ===== rtl/core/dnd_pkg.sv =====
package dnd_pkg;

  localparam int unsigned DayW   = 22;
  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayOfW = 5;

  localparam logic [DayW-1:0] DAYS_400Y = 22'd146097;
  localparam logic [DayW-1:0] DAYS_100Y = 22'd36524;
  localparam logic [DayW-1:0] DAYS_4Y   = 22'd1461;
  localparam logic [DayW-1:0] DAYS_1Y   = 22'd365;

  localparam logic [YearW-1:0] YEARS_400 = 14'd400;
  localparam logic [YearW-1:0] YEARS_100 = 14'd100;
  localparam logic [YearW-1:0] YEARS_4   = 14'd4;
  localparam logic [YearW-1:0] YEARS_1   = 14'd1;

  localparam logic [1:0]        MAX_Q100     = 2'd3;
  localparam logic [1:0]        MAX_Q1       = 2'd3;
  localparam logic [4:0]        Q4_CENTURY   = 5'd24;
  localparam logic [MonthW-1:0] MONTH_FIRST  = 4'd1;
  localparam logic [MonthW-1:0] MONTH_FEB    = 4'd2;
  localparam logic [MonthW-1:0] MONTH_LAST   = 4'd12;

  typedef enum logic [2:0] {
    PH_Y400,
    PH_Y100,
    PH_Y4,
    PH_Y1,
    PH_MONTH
  } phase_e;

  typedef struct packed {
    logic   load;
    logic   step;
    logic   emit;
    phase_e phase;
  } cmd_t;

  typedef struct packed {
    logic oor;
    logic go;
  } sts_t;

  function automatic logic [DayOfW-1:0] month_len(input logic [MonthW-1:0] month,
                                                  input logic             leap);
    logic [DayOfW-1:0] len;
    unique case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
      MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/core/dnd_if.sv =====
interface dnd_in_if;
  import dnd_pkg::*;
  logic              valid;
  logic              ready;
  logic [DayW-1:0]   day_number;

  modport source (output valid, output day_number, input ready);
  modport sink   (input valid, input day_number, output ready);
endinterface

interface dnd_out_if;
  import dnd_pkg::*;
  logic              valid;
  logic              ready;
  logic [YearW-1:0]  year_out;
  logic [MonthW-1:0] month_out;
  logic [DayOfW-1:0] day_out;
  logic              out_of_range;

  modport source (output valid, output year_out, output month_out, output day_out,
                  output out_of_range, input ready);
  modport sink   (input valid, input year_out, input month_out, input day_out,
                  input out_of_range, output ready);
endinterface

// ===== rtl/core/day_number_to_date.sv =====
// Converts a Gregorian day number (1 is 0001-01-01) into year, month and day. Day number 0
// and any day after December 31 of MAX_YEAR return zeroed date fields with out_of_range set.
// One item is converted at a time: a shared subtractor removes one span per cycle (400, 100,
// 4 and 1 years, then one month); an out-of-range item goes from the 400-year step straight
// to the output register.
// The result sits in an output register, so the next item can be taken in the cycle after that
// register is loaded even if the result has not been collected.
module day_number_to_date
  import dnd_pkg::*;
#(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dnd_in_if.sink     in_i,
  dnd_out_if.source  out_o
);

  cmd_t cmd;
  sts_t sts;

  dnd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  dnd_dp #(
    .MAX_YEAR (MAX_YEAR)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .day_number_i (in_i.day_number),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .year_o       (out_o.year_out),
    .month_o      (out_o.month_out),
    .day_o        (out_o.day_out),
    .oor_o        (out_o.out_of_range)
  );

endmodule

// ===== rtl/core/dnd_ctrl.sv =====
`include "day_number_to_date_defines.svh"

module dnd_ctrl
  import dnd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_Y400  = 7'b0000010,
    ST_Y100  = 7'b0000100,
    ST_Y4    = 7'b0001000,
    ST_Y1    = 7'b0010000,
    ST_MONTH = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o.load  = 1'b0;
    cmd_o.step  = 1'b0;
    cmd_o.emit  = 1'b0;
    cmd_o.phase = PH_Y400;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_Y400;
        end
      end
      ST_Y400: begin
        cmd_o.phase = PH_Y400;
        if (sts_i.oor) begin
          state_d = ST_DONE;
        end else if (sts_i.go) begin
          cmd_o.step = 1'b1;
        end else begin
          state_d = ST_Y100;
        end
      end
      ST_Y100: begin
        cmd_o.phase = PH_Y100;
        if (sts_i.go) begin
          cmd_o.step = 1'b1;
        end else begin
          state_d = ST_Y4;
        end
      end
      ST_Y4: begin
        cmd_o.phase = PH_Y4;
        if (sts_i.go) begin
          cmd_o.step = 1'b1;
        end else begin
          state_d = ST_Y1;
        end
      end
      ST_Y1: begin
        cmd_o.phase = PH_Y1;
        if (sts_i.go) begin
          cmd_o.step = 1'b1;
        end else begin
          state_d = ST_MONTH;
        end
      end
      ST_MONTH: begin
        cmd_o.phase = PH_MONTH;
        if (sts_i.go) begin
          cmd_o.step = 1'b1;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.emit || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `DND_ASSERT(a_emit_no_overwrite, cmd_o.emit |-> out_free, "Result overwrites a pending item.")
  `DND_ASSERT_NEXT(a_load_starts, cmd_o.load, state_q == ST_Y400, "Load did not start a conversion.")
  `DND_ASSERT(a_step_not_idle, cmd_o.step |-> !in_ready_o, "Datapath step while ready for input.")

endmodule

// ===== rtl/core/dnd_dp.sv =====
`include "day_number_to_date_defines.svh"

module dnd_dp
  import dnd_pkg::*;
#(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [DayW-1:0]   day_number_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  output logic [YearW-1:0]  year_o,
  output logic [MonthW-1:0] month_o,
  output logic [DayOfW-1:0] day_o,
  output logic              oor_o
);

  localparam int unsigned LastDay =
    365 * MAX_YEAR + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400;
  localparam logic [DayW-1:0] LAST_DAY = DayW'(LastDay);
  localparam logic [YearW-1:0] MAX_YEAR_W = YearW'(MAX_YEAR);

  logic [DayW-1:0]   n_q;
  logic [YearW-1:0]  year_q;
  logic [MonthW-1:0] month_q;
  logic [1:0]        c100_q;
  logic [4:0]        c4_q;
  logic [1:0]        c1_q;
  logic              oor_q;

  logic [YearW-1:0]  res_year_q;
  logic [MonthW-1:0] res_month_q;
  logic [DayOfW-1:0] res_day_q;
  logic              res_oor_q;

  logic              leap;
  logic [DayOfW-1:0] mlen;
  logic [DayW-1:0]   span;
  logic [YearW-1:0]  weight;
  logic              cap;

  // Year is 400*q400 + 100*q100 + 4*q4 + q1 + 1, so its divisibility follows from the counts.
  assign leap = (c1_q == MAX_Q1) && ((c4_q != Q4_CENTURY) || (c100_q == MAX_Q100));
  assign mlen = month_len(month_q, leap);

  always_comb begin
    span   = DAYS_400Y;
    weight = YEARS_400;
    cap    = 1'b0;
    unique case (cmd_i.phase)
      PH_Y400: begin
        span   = DAYS_400Y;
        weight = YEARS_400;
      end
      PH_Y100: begin
        span   = DAYS_100Y;
        weight = YEARS_100;
        cap    = (c100_q == MAX_Q100);
      end
      PH_Y4: begin
        span   = DAYS_4Y;
        weight = YEARS_4;
      end
      PH_Y1: begin
        span   = DAYS_1Y;
        weight = YEARS_1;
        cap    = (c1_q == MAX_Q1);
      end
      PH_MONTH: begin
        span   = DayW'(mlen);
        weight = '0;
        cap    = (month_q == MONTH_LAST);
      end
      default: begin
        span   = DAYS_400Y;
        weight = YEARS_400;
      end
    endcase
  end

  assign sts_o.go  = (n_q >= span) && !cap;
  assign sts_o.oor = oor_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q     <= day_number_i - DayW'(1);
      oor_q   <= (day_number_i == '0) || (day_number_i > LAST_DAY);
      year_q  <= YEARS_1;
      month_q <= MONTH_FIRST;
      c100_q  <= '0;
      c4_q    <= '0;
      c1_q    <= '0;
    end else if (cmd_i.step) begin
      n_q    <= n_q - span;
      year_q <= year_q + weight;
      unique case (cmd_i.phase)
        PH_Y100:  c100_q  <= c100_q + 2'd1;
        PH_Y4:    c4_q    <= c4_q + 5'd1;
        PH_Y1:    c1_q    <= c1_q + 2'd1;
        PH_MONTH: month_q <= month_q + MonthW'(1);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_oor_q   <= oor_q;
      res_year_q  <= oor_q ? '0 : year_q;
      res_month_q <= oor_q ? '0 : month_q;
      res_day_q   <= oor_q ? '0 : (n_q[DayOfW-1:0] + DayOfW'(1));
    end
  end

  assign year_o  = res_year_q;
  assign month_o = res_month_q;
  assign day_o   = res_day_q;
  assign oor_o   = res_oor_q;

  `DND_ASSERT(a_day_fits, (cmd_i.emit && !oor_q) |-> (n_q < DayW'(31)), "Day of month too large.")
  `DND_ASSERT(a_year_range, (cmd_i.emit && !oor_q) |-> (year_q >= YEARS_1 && year_q <= MAX_YEAR_W), "Year out of range.")
  `DND_ASSERT(a_month_range, (cmd_i.step && cmd_i.phase == PH_MONTH) |-> (month_q < MONTH_LAST), "Month steps past December.")

endmodule

// ===== bench/day_number_to_date_tb.sv =====
module day_number_to_date_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dnd_pkg::*;

  localparam int unsigned MAX_YEAR = 9999;
  localparam int unsigned LAST_DAY = 365 * MAX_YEAR + MAX_YEAR / 4 - MAX_YEAR / 100
                                     + MAX_YEAR / 400;
  localparam int unsigned RANDOM_PER_PHASE = 278;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned MONTH_DAYS [1:12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayOfW-1:0] day;
    logic              out_of_range;
  } date_t;

  typedef struct packed {
    logic [DayW-1:0] day_number;
    logic            typed;
    date_t           want;
  } vector_t;

  typedef struct packed {
    logic [DayW-1:0] day_number;
    date_t           date;
  } conversion_t;

  localparam date_t REJECTED = '{year: '0, month: '0, day: '0, out_of_range: 1'b1};

  // Rows with a typed date are checked against it; the others go through the predictor.
  localparam vector_t DIRECTED [0:21] = '{
    '{22'd0,       1'b1, REJECTED},
    '{22'd1,       1'b1, '{14'd1, 4'd1, 5'd1, 1'b0}},
    '{22'd3652059, 1'b1, '{14'd9999, 4'd12, 5'd31, 1'b0}},
    '{22'd3652060, 1'b1, REJECTED},
    '{22'd4194303, 1'b1, REJECTED},
    '{22'd31,      1'b0, '0},
    '{22'd32,      1'b0, '0},
    '{22'd59,      1'b0, '0},
    '{22'd60,      1'b0, '0},
    '{22'd365,     1'b0, '0},
    '{22'd366,     1'b0, '0},
    '{22'd1154,    1'b0, '0},
    '{22'd1155,    1'b0, '0},
    '{22'd1461,    1'b0, '0},
    '{22'd1462,    1'b0, '0},
    '{22'd36524,   1'b0, '0},
    '{22'd36525,   1'b0, '0},
    '{22'd145791,  1'b0, '0},
    '{22'd146097,  1'b0, '0},
    '{22'd146098,  1'b0, '0},
    '{22'd2097152, 1'b0, '0},
    '{22'd3651695, 1'b0, '0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  dnd_in_if  in_if ();
  dnd_out_if out_if ();

  day_number_to_date #(
    .MAX_YEAR(MAX_YEAR)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  conversion_t expected_dates[$];
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned errors = 0;
  bit          hold_request = 1'b0;
  bit          hold_served = 1'b0;
  int unsigned hold_left = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned days_through_year(input int unsigned year);
    return 365 * year + year / 4 - year / 100 + year / 400;
  endfunction

  function automatic date_t date_of_day(input logic [DayW-1:0] day_number);
    date_t       date;
    int unsigned rem;
    int unsigned years;
    int unsigned span;
    int unsigned mon;
    int unsigned mlen;
    bit          leap;
    date = '0;
    if (day_number == 0 || day_number > LAST_DAY) begin
      return REJECTED;
    end
    rem = day_number - 1;
    span = rem / DAYS_400Y;
    years = 400 * span;
    rem -= span * DAYS_400Y;
    span = rem / DAYS_100Y;
    if (span > 3) begin
      span = 3;
    end
    years += 100 * span;
    rem -= span * DAYS_100Y;
    span = rem / DAYS_4Y;
    years += 4 * span;
    rem -= span * DAYS_4Y;
    span = rem / DAYS_1Y;
    if (span > 3) begin
      span = 3;
    end
    years += span + 1;
    rem -= span * DAYS_1Y;
    leap = (years % 4 == 0) && ((years % 100 != 0) || (years % 400 == 0));
    for (mon = MONTH_FIRST; mon < MONTH_LAST; mon++) begin
      mlen = (mon == MONTH_FEB && leap) ? 29 : MONTH_DAYS[mon];
      if (rem < mlen) begin
        break;
      end
      rem -= mlen;
    end
    date.year = YearW'(years);
    date.month = MonthW'(mon);
    date.day = DayOfW'(rem + 1);
    return date;
  endfunction

  // Mostly valid days, with extra weight on year ends, the end of February and the top limit.
  function automatic logic [DayW-1:0] random_day_number();
    int unsigned pick;
    int unsigned year;
    pick = $urandom_range(99);
    year = $urandom_range(MAX_YEAR, 1);
    if (pick < 55) begin
      return DayW'($urandom_range(LAST_DAY, 1));
    end else if (pick < 70) begin
      return DayW'(days_through_year(year - 1) + $urandom_range(1, 0));
    end else if (pick < 85) begin
      return DayW'(days_through_year(year - 1) + $urandom_range(61, 58));
    end else if (pick < 90) begin
      return DayW'(LAST_DAY - 2 + $urandom_range(3, 0));
    end
    return DayW'($urandom_range(2 ** DayW - 1, 0));
  endfunction

  task automatic offer(input logic [DayW-1:0] day_number, input logic typed, input date_t want);
    conversion_t entry;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.day_number <= day_number;
    do begin
      @(posedge clk_i);
    end while (!in_if.ready);
    entry.day_number = day_number;
    entry.date = typed ? want : date_of_day(day_number);
    expected_dates.push_back(entry);
  endtask

  always @(posedge clk_i) begin : receive
    date_t       got;
    conversion_t entry;
    got = '{out_if.year_out, out_if.month_out, out_if.day_out, out_if.out_of_range};
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_dates.size() == 0) begin
        $display("%0t: unexpected item %0d-%0d-%0d oor %0b", $realtime, got.year, got.month,
                 got.day, got.out_of_range);
        errors++;
      end else begin
        entry = expected_dates.pop_front();
        if (got !== entry.date) begin
          $display("%0t: day %0d expected %0d-%0d-%0d oor %0b, got %0d-%0d-%0d oor %0b",
                   $realtime, entry.day_number, entry.date.year, entry.date.month,
                   entry.date.day, entry.date.out_of_range, got.year, got.month, got.day,
                   got.out_of_range);
          errors++;
        end
      end
    end
    if (hold_request && !hold_served) begin
      hold_served = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.day_number = '0;
    out_if.ready = 1'b0;
    send_idle_pct = 32;
    recv_idle_pct = 80;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (DIRECTED[i]) begin
      offer(DIRECTED[i].day_number, DIRECTED[i].typed, DIRECTED[i].want);
    end
    repeat (RANDOM_PER_PHASE) offer(random_day_number(), 1'b0, '0);
    send_idle_pct = 80;
    recv_idle_pct = 32;
    repeat (RANDOM_PER_PHASE) offer(random_day_number(), 1'b0, '0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 1'b1;
    repeat (RANDOM_PER_PHASE) offer(random_day_number(), 1'b0, '0);
    in_if.valid <= 1'b0;
    while (expected_dates.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS day_number_to_date");
    end else begin
      $display("FAIL day_number_to_date");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t: timed out", $realtime);
    $display("FAIL day_number_to_date");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/dnd_pkg.sv
rtl/core/dnd_if.sv
rtl/core/dnd_ctrl.sv
rtl/core/dnd_dp.sv
rtl/core/day_number_to_date.sv
bench/day_number_to_date_tb.sv
